// File: hw/rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types, codes and character classes shared by the scene text tokenizer and
// its port checker.
// ----------------------------------------------------------------------------
package stt_pkg;

	// Default position counter width and tab width
	localparam int unsigned POS_WIDTH_DEF = 16;
	localparam int unsigned POS_OUT_W     = 16;
	localparam int unsigned TAB_W         = 5;
	localparam logic [TAB_W-1:0] TAB_RESET = 5'd4;

	// Character constants
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Result record kinds
	typedef enum logic [1:0] {
		KIND_CONTENT = 2'd0,
		KIND_END     = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	// Token types
	typedef enum logic [2:0] {
		TT_BOPEN  = 3'd0,
		TT_BCLOSE = 3'd1,
		TT_COMMA  = 3'd2,
		TT_VALUE  = 3'd3,
		TT_STRING = 3'd4,
		TT_WORD   = 3'd5
	} tok_type_t;

	// Lexer modes, one-hot
	typedef enum logic [6:0] {
		MD_IDLE     = 7'b0000001,
		MD_NUMBER   = 7'b0000010,
		MD_WORD     = 7'b0000100,
		MD_STRING   = 7'b0001000,
		MD_LINECMT  = 7'b0010000,
		MD_BLOCKCMT = 7'b0100000,
		MD_SLASH    = 7'b1000000
	} mode_t;

	// Input word
	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_text;
	} in_word_t;

	// Result word
	typedef struct packed {
		kind_t                kind;
		tok_type_t            token_type;
		logic [7:0]           char_out;
		logic                 first_of_token;
		logic [POS_OUT_W-1:0] line_no;
		logic [POS_OUT_W-1:0] column_no;
		logic                 last_of_run;
	} out_word_t;

	// Digits, period, plus and minus form numeric runs
	function automatic logic is_num(input logic [7:0] c);
		return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_PERIOD) ||
			(c == CH_PLUS) || (c == CH_MINUS);
	endfunction

	// Characters that close a word
	function automatic logic ends_word(input logic [7:0] c);
		return (c == CH_NL) || (c == CH_TAB) || (c == CH_SPACE) ||
			(c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_PERIOD) ||
			(c == CH_SLASH) || (c == CH_COMMA) || (c == CH_QUOTE);
	endfunction

endpackage

// File: hw/rtl/scene_text_tokenizer.sv
// ----------------------------------------------------------------------------
// scene_text_tokenizer
// Byte-serial lexer: braces, commas, numeric runs, strings, words and
// comments; emits content bytes, end records with position, and errors.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_item  (ch, end_of_text)
//  out     | output    | out_valid / out_ready| out_item (one result record)
//  cfg     | input     | cfg_we               | cfg_wdata (tab width)
//
// Each byte is lexed in the cycle it is accepted; its zero to three results
// land in a three-entry result buffer and leave one per cycle while out_ready is high.
// A byte with at most one result sustains one byte per cycle while out_ready is high;
// a byte with more results holds the input while the single output port drains the buffer.
// Reset puts the lexer idle at line 1, column 1, with tab width 4. in_ready
// drops while more than one result is queued, or one is queued and out_ready is low.
// ----------------------------------------------------------------------------
module scene_text_tokenizer #(
	parameter int unsigned POS_WIDTH = stt_pkg::POS_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  stt_pkg::in_word_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output stt_pkg::out_word_t  out_item,
	input  logic                cfg_we,
	input  logic [stt_pkg::TAB_W-1:0] cfg_wdata
);
	import stt_pkg::*;

	localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
	localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);

	// Lexer state and configuration
	mode_t                mode_q;
	logic                 star_q;
	logic [POS_WIDTH-1:0] line_q;
	logic [POS_WIDTH-1:0] col_q;
	logic [TAB_W-1:0]     tab_q;

	// Result buffer
	out_word_t            res_s1 [3];
	logic [1:0]           cnt_s1;

	// Next-state and result list
	mode_t                mode_n;
	logic                 star_n;
	logic [POS_WIDTH-1:0] line_v;
	logic [POS_WIDTH-1:0] col_v;
	out_word_t            res_n [3];
	logic [1:0]           num_n;
	logic                 do_idle;
	tok_type_t            run_type;
	logic                 cont;
	logic [7:0]           c;
	logic                 eot;
	logic                 in_fire;
	logic                 out_fire;

	// Saturating column add
	function automatic logic [POS_WIDTH-1:0] col_add(input logic [POS_WIDTH-1:0] col,
		input logic [TAB_W-1:0] k);
		logic [POS_WIDTH:0] sum;
		sum = {1'b0, col} + (POS_WIDTH+1)'(k);
		return (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[POS_WIDTH-1:0];
	endfunction

	// Build one record; content records carry no position
	function automatic out_word_t mk(input kind_t k, input tok_type_t t,
		input logic [7:0] ch, input logic first,
		input logic [POS_WIDTH-1:0] ln, input logic [POS_WIDTH-1:0] cl);
		out_word_t r;
		r.kind           = k;
		r.token_type     = t;
		r.char_out       = ch;
		r.first_of_token = first;
		r.line_no        = (k != KIND_CONTENT) ? POS_OUT_W'(ln) : '0;
		r.column_no      = (k != KIND_CONTENT) ? POS_OUT_W'(cl) : '0;
		r.last_of_run    = 1'b0;
		return r;
	endfunction

	assign c        = in_item.ch;
	assign eot      = in_item.end_of_text;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign in_ready = (cnt_s1 == 2'd0) || ((cnt_s1 == 2'd1) && out_ready);
	assign out_valid = (cnt_s1 != 2'd0);
	assign out_item  = res_s1[0];

	// Lex one byte: results and next state
	always_comb begin
		mode_n   = mode_q;
		star_n   = star_q;
		line_v   = line_q;
		col_v    = col_q;
		num_n    = 2'd0;
		do_idle  = 1'b0;
		res_n[0] = '0;
		res_n[1] = '0;
		res_n[2] = '0;
		run_type = (mode_q == MD_NUMBER) ? TT_VALUE : TT_WORD;
		cont     = (mode_q == MD_NUMBER) ? is_num(c) : !ends_word(c);

		unique case (mode_q)
			MD_NUMBER, MD_WORD: begin
				if (cont) begin
					res_n[num_n] = mk(KIND_CONTENT, run_type, c, 1'b0, line_v, col_v);
					num_n = num_n + 2'd1;
					col_v = col_add(col_v, TAB_W'(1));
					if (eot) begin
						res_n[num_n] = mk(KIND_END, run_type, 8'h00, 1'b0, line_v, col_v);
						num_n = num_n + 2'd1;
					end
				end else begin
					res_n[num_n] = mk(KIND_END, run_type, 8'h00, 1'b0, line_v, col_v);
					num_n = num_n + 2'd1;
					do_idle = 1'b1;
				end
			end
			MD_STRING: begin
				if (c == CH_QUOTE) begin
					res_n[num_n] = mk(KIND_CONTENT, TT_STRING, c, 1'b0, line_v, col_v);
					num_n = num_n + 2'd1;
					col_v = col_add(col_v, TAB_W'(1));
					res_n[num_n] = mk(KIND_END, TT_STRING, 8'h00, 1'b0, line_v, col_v);
					num_n = num_n + 2'd1;
					mode_n = MD_IDLE;
				end else begin
					// drop newlines inside strings
					if (c == CH_NL) begin
						if (line_v != POS_MAX) line_v = line_v + POS_ONE;
						col_v = POS_ONE;
					end else begin
						res_n[num_n] = mk(KIND_CONTENT, TT_STRING, c, 1'b0, line_v, col_v);
						num_n = num_n + 2'd1;
						col_v = col_add(col_v, TAB_W'(1));
					end
					// supply the missing closing quote at end of text
					if (eot) begin
						res_n[num_n] = mk(KIND_CONTENT, TT_STRING, CH_QUOTE, 1'b0,
							line_v, col_v);
						num_n = num_n + 2'd1;
						col_v = col_add(col_v, TAB_W'(1));
						res_n[num_n] = mk(KIND_END, TT_STRING, 8'h00, 1'b0, line_v, col_v);
						num_n = num_n + 2'd1;
					end
				end
			end
			MD_LINECMT: begin
				if (c == CH_NL) do_idle = 1'b1;
				else col_v = col_add(col_v, TAB_W'(1));
			end
			MD_BLOCKCMT: begin
				if ((c == CH_SLASH) && star_q) begin
					col_v  = col_add(col_v, TAB_W'(1));
					mode_n = MD_IDLE;
				end else if (c == CH_NL) begin
					if (line_v != POS_MAX) line_v = line_v + POS_ONE;
					col_v = POS_ONE;
				end else begin
					col_v = col_add(col_v, TAB_W'(1));
				end
				star_n = (c == CH_STAR);
			end
			MD_SLASH: begin
				if (c == CH_SLASH) begin
					col_v  = col_add(col_v, TAB_W'(2));
					mode_n = MD_LINECMT;
				end else if ((c == CH_STAR) && !eot) begin
					col_v  = col_add(col_v, TAB_W'(1));
					star_n = 1'b1;
					mode_n = MD_BLOCKCMT;
				end else begin
					// stray slash: flag it, then lex this byte from idle
					res_n[num_n] = mk(KIND_ERROR, TT_BOPEN, CH_SLASH, 1'b0, line_v, col_v);
					num_n = num_n + 2'd1;
					col_v = col_add(col_v, TAB_W'(1));
					do_idle = 1'b1;
				end
			end
			default: do_idle = 1'b1;
		endcase

		// Lex from idle
		if (do_idle) begin
			mode_n = MD_IDLE;
			if (c == CH_NL) begin
				if (line_v != POS_MAX) line_v = line_v + POS_ONE;
				col_v = POS_ONE;
			end else if (c == CH_TAB) begin
				col_v = col_add(col_v, tab_q);
			end else if (c == CH_SPACE) begin
				col_v = col_add(col_v, TAB_W'(1));
			end else if ((c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_COMMA)) begin
				res_n[num_n] = mk(KIND_CONTENT,
					(c == CH_LBRACE) ? TT_BOPEN : ((c == CH_RBRACE) ? TT_BCLOSE : TT_COMMA),
					c, 1'b1, line_v, col_v);
				num_n = num_n + 2'd1;
				col_v = col_add(col_v, TAB_W'(1));
				res_n[num_n] = mk(KIND_END,
					(c == CH_LBRACE) ? TT_BOPEN : ((c == CH_RBRACE) ? TT_BCLOSE : TT_COMMA),
					8'h00, 1'b0, line_v, col_v);
				num_n = num_n + 2'd1;
			end else if (c == CH_SLASH) begin
				if (eot) begin
					res_n[num_n] = mk(KIND_ERROR, TT_BOPEN, c, 1'b0, line_v, col_v);
					num_n = num_n + 2'd1;
					col_v = col_add(col_v, TAB_W'(1));
				end else begin
					mode_n = MD_SLASH;
				end
			end else if (c == CH_QUOTE) begin
				if (eot) begin
					res_n[num_n] = mk(KIND_ERROR, TT_BOPEN, c, 1'b0, line_v, col_v);
					num_n = num_n + 2'd1;
				end else begin
					res_n[num_n] = mk(KIND_CONTENT, TT_STRING, c, 1'b1, line_v, col_v);
					num_n = num_n + 2'd1;
					col_v  = col_add(col_v, TAB_W'(1));
					mode_n = MD_STRING;
				end
			end else begin
				// start a numeric run or a word
				res_n[num_n] = mk(KIND_CONTENT, is_num(c) ? TT_VALUE : TT_WORD,
					c, 1'b1, line_v, col_v);
				num_n = num_n + 2'd1;
				col_v = col_add(col_v, TAB_W'(1));
				if (eot) begin
					res_n[num_n] = mk(KIND_END, is_num(c) ? TT_VALUE : TT_WORD,
						8'h00, 1'b0, line_v, col_v);
					num_n = num_n + 2'd1;
				end else begin
					mode_n = is_num(c) ? MD_NUMBER : MD_WORD;
				end
			end
		end

		// End of text: back to the start
		if (eot) begin
			mode_n = MD_IDLE;
			star_n = 1'b0;
			line_v = POS_ONE;
			col_v  = POS_ONE;
		end

		// Mark the final result of this byte
		if (num_n != 2'd0) res_n[num_n - 2'd1].last_of_run = 1'b1;
	end

	// Advance lexer state and take configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MD_IDLE;
			star_q <= 1'b0;
			line_q <= POS_ONE;
			col_q  <= POS_ONE;
			tab_q  <= TAB_RESET;
		end else begin
			if (in_fire) begin
				mode_q <= mode_n;
				star_q <= star_n;
				line_q <= line_v;
				col_q  <= col_v;
			end
			if (cfg_we) tab_q <= cfg_wdata;
		end
	end

	// Result count: load on accept, drop one per delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= 2'd0;
		end else if (in_fire) begin
			cnt_s1 <= num_n;
		end else if (out_fire) begin
			cnt_s1 <= cnt_s1 - 2'd1;
		end
	end

	// Result payload: load on accept, shift on delivery
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_s1[0] <= res_n[0];
			res_s1[1] <= res_n[1];
			res_s1[2] <= res_n[2];
		end else if (out_fire) begin
			res_s1[0] <= res_s1[1];
			res_s1[1] <= res_s1[2];
		end
	end

endmodule

// File: hw/rtl/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_port_props
// Port-level checks for the scene text tokenizer, bound to its top level.
// ----------------------------------------------------------------------------
module stt_port_props (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_ready,
	input  logic               out_valid,
	input  logic               out_ready,
	input  stt_pkg::out_word_t out_item
);
	import stt_pkg::*;

	// Input stalls only while results are waiting
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending result");

	// More results of the same byte follow the one just taken
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_item.last_of_run) |=> out_valid)
		else $error("result run cut short");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
		else $error("stalled result changed");

	// Content bytes carry no position
	a_content_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_item.kind == KIND_CONTENT)) |->
		((out_item.line_no == '0) && (out_item.column_no == '0)))
		else $error("content record carries a position");

	// Errors flag only a slash or a quote
	a_error_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_item.kind == KIND_ERROR)) |->
		((out_item.char_out == CH_SLASH) || (out_item.char_out == CH_QUOTE)))
		else $error("error record on unexpected character");

endmodule

bind scene_text_tokenizer stt_port_props u_stt_port_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
